// ----- rtl/iff_pkg.sv -----
// shared types, codes and character tables for the integer field formatter
package iff_pkg;

   localparam int BOUND_W = 7;

   localparam logic [1:0] BASE_DEC   = 2'd0;
   localparam logic [1:0] BASE_OCT   = 2'd1;
   localparam logic [1:0] BASE_HEX   = 2'd2;
   localparam logic [1:0] BASE_SPARE = 2'd3;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;
   localparam logic [7:0] CHAR_X_LOW = 8'h78;

   localparam logic [BOUND_W-1:0] RESULT_CAP_LAST = 7'd63;

   typedef enum logic [3:0] {
      F_IDLE   = 4'b0001,
      F_GEN    = 4'b0010,
      F_FINISH = 4'b0100,
      F_PUSH   = 4'b1000
   } front_state_type;

   // segment end positions, total length, sign character and case of one field
   typedef struct packed {
      logic [BOUND_W-1:0] lpad_end;
      logic [BOUND_W-1:0] sign_end;
      logic [BOUND_W-1:0] pfx_end;
      logic [BOUND_W-1:0] zero_end;
      logic [BOUND_W-1:0] digit_end;
      logic [BOUND_W-1:0] total;
      logic [7:0]         sign_char;
      logic               upper;
   } desc_type;

   localparam int DESC_W = $bits(desc_type);

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = 8'h30 + {4'd0, d};
      end else if (upper) begin
         c = 8'h37 + {4'd0, d};
      end else begin
         c = 8'h57 + {4'd0, d};
      end
      return c;
   endfunction

endpackage

// ----- rtl/iff_front.sv -----
// front part: accepts a request, generates digits and works out the field layout
module iff_front import iff_pkg::*; #(
   parameter int MAX_DIGITS      = 22,
   parameter int MAX_FIELD_WIDTH = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [63:0]             req_magnitude,
   input  logic                    req_negative,
   input  logic [1:0]              req_base_select,
   input  logic                    req_left_justify,
   input  logic                    req_plus_sign,
   input  logic                    req_space_sign,
   input  logic                    req_alternate_form,
   input  logic                    req_zero_pad,
   input  logic                    req_upper_case,
   input  logic [5:0]              req_field_width,
   input  logic signed [6:0]       req_precision,
   input  logic                    q_full,
   output logic                    q_push,
   output logic [MAX_DIGITS*4-1:0] q_digits,
   output desc_type                q_desc
);
   localparam int NW = $clog2(MAX_DIGITS + 1);
   localparam int IW = $clog2(MAX_DIGITS);

   front_state_type state_ff, state_in;
   logic [63:0]    work_ff, work_in;
   logic [3:0]     rem_ff, rem_in;
   logic [2:0]     step_ff, step_in;
   logic [NW-1:0]  n_ff, n_in;
   logic [3:0]     digits_ff [MAX_DIGITS];
   logic           dig_we;
   logic [3:0]     dig_wd;
   logic [1:0]     bsel_ff;
   logic           neg_ff, left_ff, plus_ff, space_ff, alt_ff, zpad_ff, upper_ff;
   logic           hasprec_ff;
   logic [5:0]     fw_ff, prec_ff;
   logic [6:0]     zeros_ff, pad_ff;
   logic           slen_ff;
   logic [1:0]     plen_ff;
   logic [7:0]     sign_ff;

   logic [3:0]     dr;
   logic [4:0]     dt;
   logic [7:0]     dq;
   logic           accept;

   logic signed [7:0] s_fw, s_n, s_prec, s_slen, s_plen, s_zeros, s_w, s_pad;
   logic           hexpfx;
   logic [3:0]     top_digit;
   logic [6:0]     b1, b2, b3, b4, b5, tot;

   assign accept = start && !busy;
   assign busy   = (state_ff != F_IDLE);

   always_comb begin
      dr = rem_ff;
      dt = 5'd0;
      dq = 8'd0;
      for (int i = 0; i < 8; i++) begin
         dt = {dr, work_ff[63-i]};
         if (dt >= 5'd10) begin
            dq[7-i] = 1'b1;
            dr = 4'(dt - 5'd10);
         end else begin
            dr = dt[3:0];
         end
      end
   end

   always_comb begin
      top_digit = (n_ff == '0) ? 4'd0 : digits_ff[IW'(n_ff - NW'(1))];
      s_fw   = {2'b00, fw_ff};
      s_n    = 8'(n_ff);
      s_prec = {2'b00, prec_ff};
      s_slen = {7'd0, (neg_ff || plus_ff || space_ff)};
      hexpfx = alt_ff && (bsel_ff > BASE_OCT) && (n_ff != '0) &&
               !((n_ff == NW'(1)) && (digits_ff[0] == 4'd0));
      s_plen = hexpfx ? 8'sd2 : 8'sd0;
      s_zeros = (hasprec_ff && (s_prec > s_n)) ? (s_prec - s_n) : 8'sd0;
      if (alt_ff && (bsel_ff == BASE_OCT) && (s_zeros == 8'sd0) &&
          ((n_ff == '0) || (top_digit != 4'd0))) begin
         s_zeros = 8'sd1;
      end
      s_w = s_fw - s_slen - s_plen - s_n;
      if (zpad_ff && !left_ff && !hasprec_ff && (s_w > s_zeros)) begin
         s_zeros = s_w;
      end
      s_pad = s_fw - s_slen - s_plen - s_zeros - s_n;
      if (s_pad < 8'sd0) begin
         s_pad = 8'sd0;
      end
   end

   always_comb begin
      b1  = left_ff ? 7'd0 : pad_ff;
      b2  = b1 + {6'd0, slen_ff};
      b3  = b2 + {5'd0, plen_ff};
      b4  = b3 + zeros_ff;
      b5  = b4 + 7'(n_ff);
      tot = b5 + (left_ff ? pad_ff : 7'd0);
   end

   always_comb begin
      state_in = state_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      n_in     = n_ff;
      dig_we   = 1'b0;
      dig_wd   = 4'd0;
      q_push   = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               work_in  = req_magnitude;
               rem_in   = 4'd0;
               step_in  = 3'd0;
               n_in     = '0;
               state_in = F_GEN;
               if (req_magnitude == 64'd0) begin
                  state_in = F_FINISH;
                  if (!(!req_precision[6] && (req_precision[5:0] == 6'd0))) begin
                     dig_we = 1'b1;
                     n_in   = NW'(1);
                  end
               end
            end
         end
         F_GEN: begin
            if ((step_ff == 3'd0) &&
                ((work_ff == 64'd0) || (n_ff == NW'(MAX_DIGITS)))) begin
               state_in = F_FINISH;
            end else if (bsel_ff == BASE_DEC) begin
               work_in = {work_ff[55:0], dq};
               step_in = step_ff + 3'd1;
               rem_in  = dr;
               if (step_ff == 3'd7) begin
                  dig_we = 1'b1;
                  dig_wd = dr;
                  n_in   = n_ff + NW'(1);
                  rem_in = 4'd0;
               end
            end else if (bsel_ff == BASE_OCT) begin
               dig_we  = 1'b1;
               dig_wd  = {1'b0, work_ff[2:0]};
               work_in = work_ff >> 3;
               n_in    = n_ff + NW'(1);
            end else begin
               dig_we  = 1'b1;
               dig_wd  = work_ff[3:0];
               work_in = work_ff >> 4;
               n_in    = n_ff + NW'(1);
            end
         end
         F_FINISH: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (tot == 7'd0) begin
               state_in = F_IDLE;
            end else if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      n_ff    <= n_in;
      if (dig_we) begin
         digits_ff[IW'(n_in - NW'(1))] <= dig_wd;
      end
      if (accept) begin
         bsel_ff    <= req_base_select;
         neg_ff     <= req_negative;
         left_ff    <= req_left_justify;
         plus_ff    <= req_plus_sign;
         space_ff   <= req_space_sign;
         alt_ff     <= req_alternate_form;
         zpad_ff    <= req_zero_pad;
         upper_ff   <= req_upper_case;
         fw_ff      <= (req_field_width > 6'(MAX_FIELD_WIDTH)) ?
                       6'(MAX_FIELD_WIDTH) : req_field_width;
         hasprec_ff <= !req_precision[6];
         prec_ff    <= req_precision[6] ? 6'd0 :
                       ((req_precision[5:0] > 6'(MAX_FIELD_WIDTH)) ?
                        6'(MAX_FIELD_WIDTH) : req_precision[5:0]);
      end
      if (state_ff == F_FINISH) begin
         zeros_ff <= 7'(s_zeros);
         pad_ff   <= 7'(s_pad);
         slen_ff  <= s_slen[0];
         plen_ff  <= s_plen[1:0];
         sign_ff  <= neg_ff ? CHAR_MINUS : (plus_ff ? CHAR_PLUS : CHAR_SPACE);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         q_digits[i*4 +: 4] = digits_ff[i];
      end
      q_desc.lpad_end  = b1;
      q_desc.sign_end  = b2;
      q_desc.pfx_end   = b3;
      q_desc.zero_end  = b4;
      q_desc.digit_end = b5;
      q_desc.total     = tot;
      q_desc.sign_char = sign_ff;
      q_desc.upper     = upper_ff;
   end

endmodule

// ----- rtl/iff_queue.sv -----
// two-entry queue between the front and back parts
module iff_queue import iff_pkg::*; #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output logic [DATA_W-1:0] head
);
   logic [DATA_W-1:0] mem_ff [2];
   logic wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= !wptr_ff;
         end
         if (pop) begin
            rptr_ff <= !rptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/iff_back.sv -----
// back part: emits one character of the head field per cycle while the queue is not empty
module iff_back import iff_pkg::*; #(
   parameter int MAX_DIGITS = 22
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  logic [MAX_DIGITS*4-1:0] q_digits,
   input  desc_type                q_desc,
   output logic                    q_pop,
   output logic                    rsp_strobe,
   output logic [7:0]              rsp_character,
   output logic                    rsp_last
);
   localparam int IW = $clog2(MAX_DIGITS);

   logic [BOUND_W-1:0] pos_ff, pos_in;
   logic               strobe_ff;
   logic [7:0]         char_ff, char_in;
   logic               last_ff, last_in;
   logic [BOUND_W-1:0] didx;
   logic [3:0]         dig;

   always_comb begin
      didx = q_desc.digit_end - 7'd1 - pos_ff;
      dig  = q_digits[IW'(didx)*4 +: 4];
      if (pos_ff < q_desc.lpad_end) begin
         char_in = CHAR_SPACE;
      end else if (pos_ff < q_desc.sign_end) begin
         char_in = q_desc.sign_char;
      end else if (pos_ff < q_desc.pfx_end) begin
         char_in = (pos_ff == q_desc.sign_end) ? CHAR_ZERO :
                   (q_desc.upper ? CHAR_X_UP : CHAR_X_LOW);
      end else if (pos_ff < q_desc.zero_end) begin
         char_in = CHAR_ZERO;
      end else if (pos_ff < q_desc.digit_end) begin
         char_in = digit_char(dig, q_desc.upper);
      end else begin
         char_in = CHAR_SPACE;
      end
      last_in = ((pos_ff + 7'd1) == q_desc.total) || (pos_ff == RESULT_CAP_LAST);
      q_pop   = q_valid && last_in;
      pos_in  = pos_ff;
      if (q_valid) begin
         pos_in = last_in ? 7'd0 : pos_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 7'd0;
         strobe_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         strobe_ff <= q_valid;
      end
      char_ff <= char_in;
      last_ff <= last_in && q_valid;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

// ----- rtl/integer_field_formatter_unit.sv -----
// printf-style integer field formatter, top level
// digits: a decimal digit comes from a byte-wise long division of the value, an octal or hex
// digit from a shift; an end check, the layout, the queue push and the output register follow
// throughput: one output character per cycle while a field is queued, up to 64 per field; the
// front takes the next request once the field is queued and is busy while the queue is full
// reset: synchronous, clears the front state, the queue and the output strobe
module integer_field_formatter_unit import iff_pkg::*; #(
   parameter int MAX_DIGITS      = 22,
   parameter int MAX_FIELD_WIDTH = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [63:0]       req_magnitude,
   input  logic              req_negative,
   input  logic [1:0]        req_base_select,
   input  logic              req_left_justify,
   input  logic              req_plus_sign,
   input  logic              req_space_sign,
   input  logic              req_alternate_form,
   input  logic              req_zero_pad,
   input  logic              req_upper_case,
   input  logic [5:0]        req_field_width,
   input  logic signed [6:0] req_precision,
   output logic              rsp_strobe,
   output logic [7:0]        rsp_character,
   output logic              rsp_last
);
   localparam int DIG_W = MAX_DIGITS * 4;
   localparam int Q_W   = DIG_W + DESC_W;

   logic             q_full, q_push, q_pop, q_valid;
   logic [DIG_W-1:0] f_digits, b_digits;
   desc_type         f_desc, b_desc;
   logic [Q_W-1:0]   q_head;

   iff_front #(
      .MAX_DIGITS(MAX_DIGITS),
      .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
   ) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_magnitude(req_magnitude), .req_negative(req_negative),
      .req_base_select(req_base_select), .req_left_justify(req_left_justify),
      .req_plus_sign(req_plus_sign), .req_space_sign(req_space_sign),
      .req_alternate_form(req_alternate_form), .req_zero_pad(req_zero_pad),
      .req_upper_case(req_upper_case), .req_field_width(req_field_width),
      .req_precision(req_precision),
      .q_full(q_full), .q_push(q_push), .q_digits(f_digits), .q_desc(f_desc)
   );

   iff_queue #(.DATA_W(Q_W)) u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data({f_digits, f_desc}), .full(q_full),
      .pop(q_pop), .valid(q_valid), .head(q_head)
   );

   assign b_digits = q_head[Q_W-1:DESC_W];
   assign b_desc   = q_head[DESC_W-1:0];

   iff_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_digits(b_digits), .q_desc(b_desc), .q_pop(q_pop),
      .rsp_strobe(rsp_strobe), .rsp_character(rsp_character), .rsp_last(rsp_last)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("transfer into full queue");

   a_last_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_strobe) else $error("last without strobe");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted transfer not started");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");

endmodule

// ----- verif/integer_field_formatter_unit_checker.sv -----
// checker for the integer field formatter: predicts each field and compares characters
`timescale 1ns / 100ps
module integer_field_formatter_unit_checker import iff_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [63:0]       req_magnitude,
   input  logic              req_negative,
   input  logic [1:0]        req_base_select,
   input  logic              req_left_justify,
   input  logic              req_plus_sign,
   input  logic              req_space_sign,
   input  logic              req_alternate_form,
   input  logic              req_zero_pad,
   input  logic              req_upper_case,
   input  logic [5:0]        req_field_width,
   input  logic signed [6:0] req_precision,
   input  logic              rsp_strobe,
   input  logic [7:0]        rsp_character,
   input  logic              rsp_last,
   output int                fail_count,
   output int                pending_chars
);

   localparam int DIGIT_LIMIT = 22;
   localparam int WIDTH_LIMIT = 48;
   localparam int CHAR_LIMIT  = 64;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } field_char_t;

   field_char_t expected_chars[$];

   function automatic logic [7:0] glyph(input logic [3:0] d, input logic up);
      if (d < 4'd10) return 8'h30 + 8'(d);
      return (up ? 8'h41 : 8'h61) + 8'(d) - 8'd10;
   endfunction

   task automatic format_field();
      logic [63:0] mag;
      logic [3:0]  digs[DIGIT_LIMIT];
      logic [7:0]  line[$];
      logic [7:0]  sign;
      logic        has_prec;
      logic [1:0]  base;
      int n, fw, prec, zeros, pad, plen, slen, w, i;
      field_char_t fc;
      mag = req_magnitude;
      base = req_base_select;
      has_prec = !req_precision[6];
      prec = has_prec ? int'(req_precision) : 0;
      fw = int'(req_field_width);
      n = 0;
      plen = 0;
      if (fw > WIDTH_LIMIT) fw = WIDTH_LIMIT;
      if (prec > WIDTH_LIMIT) prec = WIDTH_LIMIT;
      if (mag == 0 && !(has_prec && prec == 0)) begin
         digs[0] = 4'd0;
         n = 1;
      end
      while (mag != 0 && n < DIGIT_LIMIT) begin
         if (base == BASE_OCT) begin
            digs[n] = 4'(mag & 7);
            mag = mag >> 3;
         end else if (base == BASE_DEC) begin
            digs[n] = 4'(mag % 10);
            mag = mag / 10;
         end else begin
            digs[n] = 4'(mag & 15);
            mag = mag >> 4;
         end
         n++;
      end
      sign = req_negative ? CHAR_MINUS : req_plus_sign ? CHAR_PLUS
           : req_space_sign ? CHAR_SPACE : 8'h00;
      slen = (sign != 0) ? 1 : 0;
      if (req_alternate_form && base >= BASE_HEX && n > 0 && !(n == 1 && digs[0] == 0))
         plen = 2;
      zeros = (has_prec && prec > n) ? prec - n : 0;
      if (req_alternate_form && base == BASE_OCT && zeros == 0
          && (n == 0 || digs[n-1] != 0)) zeros = 1;
      if (req_zero_pad && !req_left_justify && !has_prec) begin
         w = fw - slen - plen - n;
         if (w > zeros) zeros = w;
      end
      pad = fw - slen - plen - zeros - n;
      if (pad < 0) pad = 0;
      if (!req_left_justify) for (i = 0; i < pad; i++) line.push_back(CHAR_SPACE);
      if (slen != 0) line.push_back(sign);
      if (plen != 0) begin
         line.push_back(CHAR_ZERO);
         line.push_back(req_upper_case ? CHAR_X_UP : CHAR_X_LOW);
      end
      for (i = 0; i < zeros; i++) line.push_back(CHAR_ZERO);
      for (i = n - 1; i >= 0; i--) line.push_back(glyph(digs[i], req_upper_case));
      if (req_left_justify) for (i = 0; i < pad; i++) line.push_back(CHAR_SPACE);
      for (i = 0; i < line.size() && i < CHAR_LIMIT; i++) begin
         fc.character = line[i];
         fc.last = (i == line.size() - 1 || i == CHAR_LIMIT - 1);
         expected_chars.push_back(fc);
      end
   endtask

   always @(posedge clock) begin
      field_char_t want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected character %h", rsp_character);
               fail_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_character !== want.character) begin
                  $error("character expected %h actual %h", want.character, rsp_character);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last expected %b actual %b", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (start && !busy) format_field();
      end
      pending_chars = expected_chars.size();
   end

   initial begin
      fail_count = 0;
      pending_chars = 0;
   end

endmodule

// ----- verif/integer_field_formatter_unit_tb.sv -----
// testbench top for the integer field formatter: stimulus, watchdog and verdict
`timescale 1ns / 100ps
module integer_field_formatter_unit_tb import iff_pkg::*;;

   localparam int WATCHDOG_LIMIT = 20000;

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   logic [63:0]       req_magnitude = 0;
   logic              req_negative = 0;
   logic [1:0]        req_base_select = 0;
   logic              req_left_justify = 0;
   logic              req_plus_sign = 0;
   logic              req_space_sign = 0;
   logic              req_alternate_form = 0;
   logic              req_zero_pad = 0;
   logic              req_upper_case = 0;
   logic [5:0]        req_field_width = 0;
   logic signed [6:0] req_precision = 0;
   logic              rsp_strobe;
   logic [7:0]        rsp_character;
   logic              rsp_last;
   int                fail_count;
   int                pending_chars;
   int                idle_cycles = 0;
   int                gap_pct = 0;

   always #4 clock = ~clock;

   integer_field_formatter_unit dut (.*);
   integer_field_formatter_unit_checker checker_inst (.*);

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL integer_field_formatter_unit");
         $finish;
      end
   end

   task automatic send_field(input logic [63:0] mag, input logic [1:0] base,
                             input logic [6:0] flags, input logic [5:0] fw,
                             input logic signed [6:0] prec);
      while ($urandom_range(99) < gap_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_magnitude <= mag;
      req_base_select <= base;
      {req_negative, req_left_justify, req_plus_sign, req_space_sign,
       req_alternate_form, req_zero_pad, req_upper_case} <= flags;
      req_field_width <= fw;
      req_precision <= prec;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [63:0] random_magnitude();
      case ($urandom_range(4))
         0: return 64'($urandom_range(20));
         1: return {$urandom, $urandom};
         2: return 64'hffff_ffff_ffff_ffff - 64'($urandom_range(3));
         3: return 64'($urandom) >> $urandom_range(31);
         default: return {$urandom, $urandom} >> $urandom_range(63);
      endcase
   endfunction

   task automatic random_fields(input int count);
      logic signed [6:0] prec;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: prec = -7'sd1;
            1: prec = 7'($urandom_range(127));
            default: prec = 7'($urandom_range(12));
         endcase
         send_field(random_magnitude(), 2'($urandom_range(3)), 7'($urandom),
                    ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(16)), prec);
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 0;
      send_field(64'd0, BASE_DEC, 7'b0, 6'd0, 7'sd0);
      send_field(64'd0, BASE_DEC, 7'b0, 6'd5, 7'sd0);
      send_field(64'd0, BASE_OCT, 7'b0000100, 6'd0, 7'sd0);
      send_field(64'd0, BASE_HEX, 7'b0000100, 6'd4, -7'sd1);
      send_field(64'hffff_ffff_ffff_ffff, BASE_DEC, 7'b1111111, 6'd63, 7'sd63);
      send_field(64'hffff_ffff_ffff_ffff, BASE_OCT, 7'b0000100, 6'd0, -7'sd1);
      send_field(64'hffff_ffff_ffff_ffff, BASE_HEX, 7'b0000101, 6'd30, -7'sd1);
      send_field(64'hdead_beef, BASE_SPARE, 7'b0000100, 6'd20, -7'sd1);
      send_field(64'd8, BASE_OCT, 7'b0000100, 6'd0, 7'sd4);
      send_field(64'd8, BASE_OCT, 7'b0000100, 6'd0, 7'sd1);
      send_field(64'd42, BASE_DEC, 7'b1010000, 6'd8, -7'sd1);
      send_field(64'd42, BASE_DEC, 7'b0011000, 6'd8, -7'sd1);
      send_field(64'd42, BASE_DEC, 7'b0001010, 6'd8, -7'sd1);
      send_field(64'd42, BASE_DEC, 7'b0100010, 6'd8, -7'sd1);
      send_field(64'd42, BASE_DEC, 7'b0000010, 6'd8, 7'sd3);
      send_field(64'd42, BASE_DEC, 7'b0000000, 6'd8, -7'sd40);
      send_field(64'h1234_abcd, BASE_HEX, 7'b0100101, 6'd50, 7'sd60);
      send_field(64'd7, BASE_DEC, 7'b0000000, 6'd48, 7'sd48);
      gap_pct = 36;
      random_fields(110);
      gap_pct = 88;
      random_fields(110);
      gap_pct = 0;
      random_fields(110);
      start <= 0;
      while (pending_chars != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) $display("PASS integer_field_formatter_unit");
      else $display("FAIL integer_field_formatter_unit");
      $finish;
   end

endmodule
